@@ rtl/fsc_pkg.sv @@
`default_nettype none

package fsc_pkg;

  localparam int DATA_W          = 16;
  localparam int LABEL_W         = 10;
  localparam int MAX_NEURONS_DEF = 1024;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // word index of each configuration register (byte address / 4)
  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] potential;
    logic                     step_end;
    logic                     sample_end;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/first_spike_classifier_top.sv @@
`default_nettype none

// First-to-spike classifier. Potentials stream in step by step, neuron by
// neuron, with step_end on the last neuron of a step and sample_end on the
// last item of a sample. On the sample_end transaction the block reports the
// lowest-indexed neuron of the earliest step whose potential rose strictly
// above spike_threshold (by_spike = 1), or, if nothing spiked, the argmax of
// the last step with the first index winning ties (by_spike = 0). One item is
// taken every cycle while in_stall is low. An item passes the input register,
// then the compare/update stage, and out_valid is registered when its
// sample_end item is processed there; in_stall rises only while a sample_end
// item waits behind a result that out_stall holds. Steps longer than
// MAX_NEURONS wrap to a new step.
// spike_threshold (register 0, byte address 0) is to be written over the APB
// port only while the block is idle; the block itself does not enforce this.

module first_spike_classifier_top
  import fsc_pkg::*;
#(
  parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0]    pwdata,
  output logic      [APB_DATA_W-1:0]    prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] potential,
  input  wire logic                     step_end,
  input  wire logic                     sample_end,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [LABEL_W-1:0]            label,
  output logic                          by_spike
);

  logic signed [DATA_W-1:0] threshold;
  item_t                    in_item;
  item_t                    s1_item;
  logic                     s1_valid;
  logic                     go;

  assign in_item.potential  = potential;
  assign in_item.step_end   = step_end;
  assign in_item.sample_end = sample_end;

  fsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  fsc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .go       (go),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  fsc_core #(
    .MAX_NEURONS (MAX_NEURONS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .valid     (s1_valid),
    .item      (s1_item),
    .go        (go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .label     (label),
    .by_spike  (by_spike)
  );

endmodule

`default_nettype wire

@@ rtl/fsc_cfg.sv @@
`default_nettype none

module fsc_cfg
  import fsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0]    pwdata,
  output logic      [APB_DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic signed [DATA_W-1:0]      threshold
);

  reg_idx_t reg_sel;
  logic     wr_en;

  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (wr_en && (reg_sel == REG_THRESHOLD)) begin
      threshold <= signed'(pwdata[DATA_W-1:0]);
    end
  end

  always_comb begin
    case (reg_sel)
      REG_THRESHOLD: prdata = APB_DATA_W'(threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/fsc_in_reg.sv @@
`default_nettype none

module fsc_in_reg
  import fsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  go,
  output logic       valid,
  output item_t      item
);

  // holds one transaction; refills in the same cycle the core consumes it
  logic load;

  assign in_stall = valid && !go;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (go) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fsc_core.sv @@
`default_nettype none

module fsc_core
  import fsc_pkg::*;
#(
  parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic signed [DATA_W-1:0] threshold,
  input  wire logic                 valid,
  input  wire item_t                item,
  output logic                      go,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [LABEL_W-1:0]        label,
  output logic                      by_spike
);

  localparam int POS_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_NEURONS - 1);

  logic [POS_W-1:0]         pos;
  logic                     spike_found;
  logic [POS_W-1:0]         spike_winner;
  logic signed [DATA_W-1:0] step_best_value;
  logic [POS_W-1:0]         step_best_index;

  logic                     hit;
  logic                     take_best;
  logic                     found_next;
  logic [POS_W-1:0]         winner_next;
  logic [POS_W-1:0]         best_index_next;
  logic                     out_busy;

  // only a sample-ending item needs the result register
  assign out_busy = out_valid && out_stall;
  assign go       = valid && (!item.sample_end || !out_busy);

  assign hit             = !spike_found && (item.potential > threshold);
  assign take_best       = (pos == '0) || (item.potential > step_best_value);
  assign found_next      = spike_found || hit;
  assign winner_next     = hit ? pos : spike_winner;
  assign best_index_next = take_best ? pos : step_best_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      spike_found     <= 1'b0;
      spike_winner    <= '0;
      step_best_value <= '0;
      step_best_index <= '0;
    end else if (go) begin
      if (item.sample_end) begin
        pos             <= '0;
        spike_found     <= 1'b0;
        spike_winner    <= '0;
        step_best_value <= '0;
        step_best_index <= '0;
      end else begin
        // a step that runs past the array wraps and starts a new step
        pos             <= (item.step_end || pos == POS_LAST) ? '0 : pos + 1'b1;
        spike_found     <= found_next;
        spike_winner    <= winner_next;
        if (take_best) begin
          step_best_value <= item.potential;
        end
        step_best_index <= best_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && item.sample_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && item.sample_end) begin
      label    <= found_next ? LABEL_W'(winner_next) : LABEL_W'(best_index_next);
      by_spike <= found_next;
    end
  end

endmodule

`default_nettype wire
